FILE: rtl/qvr_pkg.sv
// Package for the quaternion vector rotation unit: shared sizes, matrix indices and the pipeline control type.
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int NUM_AXES = 3;
    localparam int NUM_COEF = NUM_AXES * NUM_AXES;

    // rotation matrix entries, row major: entry (r, c) at r * NUM_AXES + c
    localparam int C_XX = 0;
    localparam int C_XY = 1;
    localparam int C_XZ = 2;
    localparam int C_YX = 3;
    localparam int C_YY = 4;
    localparam int C_YZ = 5;
    localparam int C_ZX = 6;
    localparam int C_ZY = 7;
    localparam int C_ZZ = 8;

    typedef struct packed {
        logic en;
    } t_pipe_ctl;

endpackage

FILE: rtl/quaternion_vector_rotate_unit.sv
// Top level: pipelined fixed-point rotation of a 3-vector by a quaternion.
`timescale 1ns / 1ps
//
// Usage:
// - Slave stream s_axis_*: one item per handshake holds quaternion (w, x, y, z)
//   in signed Q1.FRAC_BITS and a signed integer vector (x, y, z).
// - Master stream m_axis_*: one item per input item, the vector part of
//   q * v * conj(q), rounded to nearest (ties up) and clipped to DATA_WIDTH
//   bits; tuser is set when any component was clipped.
// - Throughput is one item per cycle while the receiver does not stall,
//   through the six-stage multiply/add pipeline.
// - No normalization: a non-unit quaternion scales the result by |q|^2.
// - Reset (i_rst_n low, synchronous) empties the pipeline; data registers are not reset.
// - When the receiver stalls, the whole pipeline holds and s_axis_tready
//   drops only if the output register is full; nothing is lost or repeated.
//
module quaternion_vector_rotate_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, zero fill
    input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // rot_x, rot_y, rot_z, zero fill
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
    // saturated
    output logic [0:0]                                  m_axis_tuser
);

    localparam int DW     = DATA_WIDTH;
    localparam int OUT_W  = ((3 * DATA_WIDTH + 7) / 8) * 8;
    localparam int CW     = 2 * DW + 2;
    localparam int LW     = 2 * DW + 1;
    localparam int HW     = 2 * DW + 2;
    localparam int TW     = 3 * DW + 2;
    localparam int EW     = 3 * DW + 5 + 2 * FRAC_BITS;
    localparam int STAGES = 6;
    localparam int NA     = qvr_pkg::NUM_AXES;

    localparam logic signed [EW-1:0] HALF =
        {{(EW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS - 1);
    localparam logic signed [EW-1:0] SAT_MAX = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_MIN = {{(EW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};

    qvr_pkg::t_pipe_ctl ctl;

    logic [STAGES-1:0]       r_vld;
    logic signed [DW-1:0]    r1_vec [NA];
    logic signed [DW-1:0]    r2_vec [NA];
    logic signed [CW-1:0]    coef   [qvr_pkg::NUM_COEF];
    logic signed [LW-1:0]    r3_lo  [qvr_pkg::NUM_COEF];
    logic signed [HW-1:0]    r3_hi  [qvr_pkg::NUM_COEF];
    logic signed [TW-1:0]    r4_term[qvr_pkg::NUM_COEF];
    logic signed [EW-1:0]    r5_sum [NA];
    logic signed [EW-1:0]    shifted[NA];
    logic [NA-1:0]           clip;
    logic [DW-1:0]           n_rot  [NA];
    logic [DW-1:0]           r_rot  [NA];
    logic                    r_sat;

    assign ctl.en        = !r_vld[STAGES-1] || m_axis_tready;
    assign s_axis_tready = ctl.en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ctl.en) begin
            r_vld <= {r_vld[STAGES-2:0], s_axis_tvalid};
        end
    end

    qvr_coef #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_coef (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_quat_w (s_axis_tdata[0*DW +: DW]),
        .i_quat_x (s_axis_tdata[1*DW +: DW]),
        .i_quat_y (s_axis_tdata[2*DW +: DW]),
        .i_quat_z (s_axis_tdata[3*DW +: DW]),
        .o_coef   (coef)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            for (int a = 0; a < NA; a++) begin
                r1_vec[a] <= s_axis_tdata[(4+a)*DW +: DW];
                r2_vec[a] <= r1_vec[a];
            end
        end
    end

    // coefficient split into a signed high part and an unsigned low part
    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            for (int r = 0; r < NA; r++) begin
                for (int c = 0; c < NA; c++) begin
                    r3_lo[r*NA+c] <= $signed({1'b0, coef[r*NA+c][DW-1:0]}) * r2_vec[c];
                    r3_hi[r*NA+c] <= $signed(coef[r*NA+c][CW-1:DW]) * r2_vec[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            for (int k = 0; k < qvr_pkg::NUM_COEF; k++) begin
                r4_term[k] <= (TW'(r3_hi[k]) <<< DW) + TW'(r3_lo[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            for (int r = 0; r < NA; r++) begin
                r5_sum[r] <= EW'(r4_term[r*NA]) + EW'(r4_term[r*NA+1])
                           + EW'(r4_term[r*NA+2]) + HALF;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NA; r++) begin
            shifted[r] = r5_sum[r] >>> (2 * FRAC_BITS);
            clip[r]    = (shifted[r] > SAT_MAX) || (shifted[r] < SAT_MIN);
            if (!clip[r]) begin
                n_rot[r] = shifted[r][DW-1:0];
            end else if (shifted[r][EW-1]) begin
                n_rot[r] = OUT_MIN;
            end else begin
                n_rot[r] = OUT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en) begin
            r_rot <= n_rot;
            r_sat <= |clip;
        end
    end

    assign m_axis_tvalid   = r_vld[STAGES-1];
    assign m_axis_tdata    = OUT_W'({r_rot[2], r_rot[1], r_rot[0]});
    assign m_axis_tuser[0] = r_sat;

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            r_rot[0] == OUT_MAX || r_rot[0] == OUT_MIN ||
            r_rot[1] == OUT_MAX || r_rot[1] == OUT_MIN ||
            r_rot[2] == OUT_MAX || r_rot[2] == OUT_MIN)
        else $error("saturation flag without a clipped component");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted item missing from first stage");
`endif

endmodule

FILE: rtl/qvr_coef.sv
// Two-stage quaternion to rotation matrix coefficient pipeline.
`timescale 1ns / 1ps

module qvr_coef #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                          i_clk,
    input  qvr_pkg::t_pipe_ctl            i_ctl,
    input  logic signed [DATA_WIDTH-1:0]  i_quat_w,
    input  logic signed [DATA_WIDTH-1:0]  i_quat_x,
    input  logic signed [DATA_WIDTH-1:0]  i_quat_y,
    input  logic signed [DATA_WIDTH-1:0]  i_quat_z,
    output logic signed [2*DATA_WIDTH+1:0] o_coef [qvr_pkg::NUM_COEF]
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int CW = 2 * DATA_WIDTH + 2;

    logic signed [PW-1:0] r_ww, r_xx, r_yy, r_zz;
    logic signed [PW-1:0] r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [CW-1:0] r_coef [qvr_pkg::NUM_COEF];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_ww <= i_quat_w * i_quat_w;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_xz <= i_quat_x * i_quat_z;
            r_yz <= i_quat_y * i_quat_z;
            r_wx <= i_quat_w * i_quat_x;
            r_wy <= i_quat_w * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_coef[qvr_pkg::C_XX] <= CW'(r_ww) + CW'(r_xx) - CW'(r_yy) - CW'(r_zz);
            r_coef[qvr_pkg::C_YY] <= CW'(r_ww) - CW'(r_xx) + CW'(r_yy) - CW'(r_zz);
            r_coef[qvr_pkg::C_ZZ] <= CW'(r_ww) - CW'(r_xx) - CW'(r_yy) + CW'(r_zz);
            r_coef[qvr_pkg::C_XY] <= (CW'(r_xy) - CW'(r_wz)) <<< 1;
            r_coef[qvr_pkg::C_XZ] <= (CW'(r_xz) + CW'(r_wy)) <<< 1;
            r_coef[qvr_pkg::C_YX] <= (CW'(r_xy) + CW'(r_wz)) <<< 1;
            r_coef[qvr_pkg::C_YZ] <= (CW'(r_yz) - CW'(r_wx)) <<< 1;
            r_coef[qvr_pkg::C_ZX] <= (CW'(r_xz) - CW'(r_wy)) <<< 1;
            r_coef[qvr_pkg::C_ZY] <= (CW'(r_yz) + CW'(r_wx)) <<< 1;
        end
    end

    assign o_coef = r_coef;

endmodule

FILE: sim/tb_top.sv
// Testbench for quaternion_vector_rotate_unit: random and directed items checked by a scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int IN_W = ((7 * DW + 7) / 8) * 8;
    localparam int OUT_W = ((3 * DW + 7) / 8) * 8;
    localparam int NUM_RANDOM = 1300;
    localparam int HOLD_AT = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam longint SAT_MAX = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;

    typedef logic [3:0][DW-1:0] t_quat_word;
    typedef logic [qvr_pkg::NUM_AXES-1:0][DW-1:0] t_vec_word;
    typedef struct packed {
        t_vec_word  vec;
        t_quat_word quat;
    } t_in_word;
    typedef struct packed {
        logic      sat;
        t_vec_word comp;
    } t_rot_word;

    class rotation_scoreboard;
        t_rot_word expected_rot[$];
        int        errors = 0;

        function automatic logic [DW-1:0] round_clip(input longint acc, inout logic clip);
            longint r;
            r = (acc + (64'sd1 <<< (2 * FB - 1))) >>> (2 * FB);
            if (r > SAT_MAX) begin
                clip = 1'b1;
                r = SAT_MAX;
            end else if (r < SAT_MIN) begin
                clip = 1'b1;
                r = SAT_MIN;
            end
            return r[DW-1:0];
        endfunction

        function automatic t_rot_word rotate_vector(input t_in_word item);
            longint w, x, y, z, vx, vy, vz;
            longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
            longint acc_x, acc_y, acc_z;
            t_rot_word res;
            logic clip;
            w  = longint'($signed(item.quat[0]));
            x  = longint'($signed(item.quat[1]));
            y  = longint'($signed(item.quat[2]));
            z  = longint'($signed(item.quat[3]));
            vx = longint'($signed(item.vec[0]));
            vy = longint'($signed(item.vec[1]));
            vz = longint'($signed(item.vec[2]));
            ww = w * w; xx = x * x; yy = y * y; zz = z * z;
            xy = x * y; xz = x * z; yz = y * z;
            wx = w * x; wy = w * y; wz = w * z;
            acc_x = vx * (ww + xx - yy - zz) + 2 * vy * (xy - wz) + 2 * vz * (xz + wy);
            acc_y = 2 * vx * (xy + wz) + vy * (ww - xx + yy - zz) + 2 * vz * (yz - wx);
            acc_z = 2 * vx * (xz - wy) + 2 * vy * (yz + wx) + vz * (ww - xx - yy + zz);
            clip = 1'b0;
            res.comp[0] = round_clip(acc_x, clip);
            res.comp[1] = round_clip(acc_y, clip);
            res.comp[2] = round_clip(acc_z, clip);
            res.sat = clip;
            return res;
        endfunction

        function void add_item(input t_in_word item);
            expected_rot.push_back(rotate_vector(item));
        endfunction

        function void check_result(input t_vec_word comp, input logic sat);
            t_rot_word exp_r;
            if (expected_rot.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d sat=%0b", $time,
                         $signed(comp[0]), $signed(comp[1]), $signed(comp[2]), sat);
                errors++;
                return;
            end
            exp_r = expected_rot.pop_front();
            for (int a = 0; a < qvr_pkg::NUM_AXES; a++) begin
                if (comp[a] !== exp_r.comp[a]) begin
                    $display("%0t: rot axis %0d mismatch expected %0d actual %0d", $time, a,
                             $signed(exp_r.comp[a]), $signed(comp[a]));
                    errors++;
                end
            end
            if (sat !== exp_r.sat) begin
                $display("%0t: saturated mismatch expected %0b actual %0b", $time,
                         exp_r.sat, sat);
                errors++;
            end
        endfunction

        function int pending_count();
            return expected_rot.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;   // rot_x, rot_y, rot_z
    logic [0:0]         m_axis_tuser;   // saturated

    rotation_scoreboard rot_sb;
    int  idle_cycles = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;

    quaternion_vector_rotate_unit #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        rot_sb = new();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                rot_sb.add_item(t_in_word'(s_axis_tdata[7*DW-1:0]));
            if (m_axis_tvalid && m_axis_tready)
                rot_sb.check_result(t_vec_word'(m_axis_tdata[3*DW-1:0]), m_axis_tuser[0]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic t_in_word make_item(input int w, input int x, input int y, input int z,
                                           input int vx, input int vy, input int vz);
        t_in_word item;
        item.quat[0] = w[DW-1:0];
        item.quat[1] = x[DW-1:0];
        item.quat[2] = y[DW-1:0];
        item.quat[3] = z[DW-1:0];
        item.vec[0] = vx[DW-1:0];
        item.vec[1] = vy[DW-1:0];
        item.vec[2] = vz[DW-1:0];
        return item;
    endfunction

    function automatic int edge_value();
        case ($urandom_range(0, 6))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return 1;
            4: return -1;
            5: return 16384;
            default: return -16384;
        endcase
    endfunction

    function automatic t_in_word random_item();
        t_in_word item;
        real q[4];
        real norm, scale;
        int  kind;
        kind = $urandom_range(0, 9);
        for (int a = 0; a < qvr_pkg::NUM_AXES; a++)
            item.vec[a] = DW'($urandom_range(0, 65535));
        if (kind < 5) begin
            norm = 0.0;
            for (int k = 0; k < 4; k++) begin
                q[k] = real'(int'($urandom_range(0, 65535)) - 32768) / 32768.0;
                norm = norm + q[k] * q[k];
            end
            norm = $sqrt(norm);
            if (norm < 0.01) begin
                q[0] = 1.0;
                norm = 1.0;
            end
            scale = ($urandom_range(0, 7) == 0) ? 23000.0 : 16384.0;
            for (int k = 0; k < 4; k++)
                item.quat[k] = DW'($rtoi(q[k] / norm * scale));
        end else if (kind < 8) begin
            for (int k = 0; k < 4; k++)
                item.quat[k] = DW'($urandom_range(0, 65535));
        end else begin
            for (int k = 0; k < 4; k++)
                item.quat[k] = DW'(edge_value());
            for (int a = 0; a < qvr_pkg::NUM_AXES; a++)
                if ($urandom_range(0, 1))
                    item.vec[a] = DW'(edge_value());
        end
        return item;
    endfunction

    task automatic send_item(input t_in_word item, input bit no_gap);
        int gap;
        gap = (no_gap || send_burst) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(item);
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        int n_done;
        int stall;
        n_done = 0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            if (n_done == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = recv_burst ? 0 : $urandom_range(0, 11);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            n_done++;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity, zero and axis rotations
        send_item(make_item(16384, 0, 0, 0, 32767, -32768, 1), 1'b0);
        send_item(make_item(16384, 0, 0, 0, -1, 0, -32768), 1'b0);
        send_item(make_item(-16384, 0, 0, 0, -32768, 32767, 0), 1'b0);
        send_item(make_item(16384, 0, 0, 0, 0, 0, 0), 1'b0);
        send_item(make_item(0, 0, 0, 0, 32767, 32767, 32767), 1'b0);
        send_item(make_item(11585, 11585, 0, 0, 1000, 2000, 3000), 1'b0);
        send_item(make_item(11585, 0, 11585, 0, 1000, 2000, 3000), 1'b0);
        send_item(make_item(11585, 0, 0, 11585, 1000, 2000, 3000), 1'b0);
        send_item(make_item(11585, -11585, 0, 0, -5000, 7000, -9000), 1'b0);
        // half-turn that overflows the negated minimum
        send_item(make_item(0, 16384, 0, 0, 32767, -32768, 12345), 1'b0);
        send_item(make_item(0, 0, 16384, 0, -32768, 32767, -32768), 1'b0);
        // rounding ties, both signs
        send_item(make_item(0, 8192, 0, 0, 2, 0, 0), 1'b0);
        send_item(make_item(0, 8192, 0, 0, -2, 0, 0), 1'b0);
        send_item(make_item(0, 8192, 0, 0, 6, -6, 0), 1'b0);
        // non-unit quaternions and saturation
        send_item(make_item(32767, 0, 0, 0, 20000, -20000, 5), 1'b0);
        send_item(make_item(-32768, 0, 0, 0, 8191, -8192, 8192), 1'b0);
        send_item(make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768), 1'b0);
        send_item(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0);
        send_item(make_item(32767, -32768, 32767, -32768, 32767, -32768, 32767), 1'b0);
        send_item(make_item(1, 1, 1, 1, 1, -1, 1), 1'b0);
        send_item(make_item(8192, 8192, 8192, 8192, -32768, 32767, -1), 1'b0);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if ($urandom_range(0, 39) == 0)
                send_burst = !send_burst;
            send_item(random_item(), (i >= 20 && i < 160));
        end
        s_axis_tvalid <= 1'b0;

        while (rot_sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rot_sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: quaternion_vector_rotate_unit.f
rtl/qvr_pkg.sv
rtl/qvr_coef.sv
rtl/quaternion_vector_rotate_unit.sv
sim/tb_top.sv
